### rtl/core/pcq_pkg.sv
// shared types, mode codes and color tables of the palette color quantizer
package pcq_pkg;

  // number of colors in the fixed palette
  localparam int unsigned PAL_LEN = 10;

  // color mode register codes
  localparam logic [1:0] MODE_TABLE   = 2'd0;
  localparam logic [1:0] MODE_NEAREST = 2'd1;
  localparam logic [1:0] MODE_PASS    = 2'd2;

  // word handed from one cell to the next
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [1:0] mode;
    logic [9:0] score;
    logic [3:0] idx;
  } cell_word_t;

  // palette color as red, green, blue
  function automatic logic [23:0] pal_rgb(input logic [3:0] k);
    logic [23:0] c;
    case (k)
      4'd0:    c = 24'h000000;
      4'd1:    c = 24'h2f002f;
      4'd2:    c = 24'h204020;
      4'd3:    c = 24'h8080b0;
      4'd4:    c = 24'he0b000;
      4'd5:    c = 24'hb01020;
      4'd6:    c = 24'he08080;
      4'd7:    c = 24'he06020;
      4'd8:    c = 24'he0b020;
      4'd9:    c = 24'h80e0e0;
      default: c = 24'h000000;
    endcase
    return c;
  endfunction

  // per-channel quantize tables, indexed by the top three bits
  function automatic logic [7:0] tab_red(input logic [2:0] k);
    logic [7:0] v;
    case (k)
      3'd0:    v = 8'h00;
      3'd1:    v = 8'h20;
      3'd2:    v = 8'h20;
      3'd3:    v = 8'h80;
      3'd4:    v = 8'h80;
      default: v = 8'he0;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] tab_green(input logic [2:0] k);
    logic [7:0] v;
    case (k)
      3'd0:    v = 8'h00;
      3'd1:    v = 8'h20;
      3'd2:    v = 8'h20;
      3'd3:    v = 8'h20;
      3'd4:    v = 8'h20;
      3'd5:    v = 8'h80;
      3'd6:    v = 8'h80;
      default: v = 8'he0;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] tab_blue(input logic [2:0] k);
    logic [7:0] v;
    case (k)
      3'd0:    v = 8'h00;
      3'd1:    v = 8'h20;
      3'd2:    v = 8'h20;
      3'd3:    v = 8'h40;
      3'd4:    v = 8'h60;
      3'd5:    v = 8'h60;
      3'd6:    v = 8'h60;
      default: v = 8'he0;
    endcase
    return v;
  endfunction

endpackage

### rtl/core/pcq_if.sv
// pixel input and result output stream interfaces
interface pcq_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_red;
  logic [7:0] pixel_green;
  logic [7:0] pixel_blue;

  modport source (output valid, output pixel_red, output pixel_green, output pixel_blue,
                  input ready);
  modport sink (input valid, input pixel_red, input pixel_green, input pixel_blue,
                output ready);
endinterface

interface pcq_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [3:0] chosen_entry;

  modport source (output valid, output out_red, output out_green, output out_blue,
                  output chosen_entry, input ready);
  modport sink (input valid, input out_red, input out_green, input out_blue,
                input chosen_entry, output ready);
endinterface

### rtl/core/pcq_cell.sv
// one palette cell: compares the pixel to one palette color and keeps the nearest
module pcq_cell
  import pcq_pkg::*;
#(
  parameter int unsigned IDX = 0
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  cell_word_t in_word_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output cell_word_t out_word_o
);

  localparam logic [3:0]  IDX_C = IDX[3:0];
  localparam logic [23:0] COLOR = pal_rgb(IDX_C);

  logic       valid_q;
  cell_word_t word_q, word_d;
  logic [9:0] cur_score;

  // xor distance to this cell's color
  assign cur_score = {2'b00, COLOR[23:16] ^ in_word_i.red}
                   + {2'b00, COLOR[15:8] ^ in_word_i.green}
                   + {2'b00, COLOR[7:0] ^ in_word_i.blue};

  // first cell seeds the search, later cells replace only on a strictly smaller distance
  always_comb begin
    word_d = in_word_i;
    if (IDX == 0 || cur_score < in_word_i.score) begin
      word_d.score = cur_score;
      word_d.idx   = IDX_C;
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      word_q <= word_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

endmodule

### rtl/core/pcq_out_stage.sv
// output register: applies the color mode and holds the finished word
module pcq_out_stage
  import pcq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  cell_word_t in_word_i,
  pcq_res_if.source  res_o
);

  logic       valid_q;
  logic [7:0] red_q, green_q, blue_q, red_d, green_d, blue_d;
  logic [3:0] entry_q, entry_d;
  logic [23:0] pal_c;

  assign pal_c = pal_rgb(in_word_i.idx);

  // pick the result by mode
  always_comb begin
    red_d   = in_word_i.red;
    green_d = in_word_i.green;
    blue_d  = in_word_i.blue;
    entry_d = 4'd0;
    case (in_word_i.mode)
      MODE_TABLE: begin
        red_d   = tab_red(in_word_i.red[7:5]);
        green_d = tab_green(in_word_i.green[7:5]);
        blue_d  = tab_blue(in_word_i.blue[7:5]);
      end
      MODE_NEAREST: begin
        red_d   = pal_c[23:16];
        green_d = pal_c[15:8];
        blue_d  = pal_c[7:0];
        entry_d = in_word_i.idx;
      end
      default: begin
        entry_d = 4'd0;
      end
    endcase
  end

  assign in_ready_o = !valid_q || res_o.ready;

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
      entry_q <= entry_d;
    end
  end

  assign res_o.valid        = valid_q;
  assign res_o.out_red      = red_q;
  assign res_o.out_green    = green_q;
  assign res_o.out_blue     = blue_q;
  assign res_o.chosen_entry = entry_q;

endmodule

### rtl/core/palette_color_quantizer.sv
// top level of the palette color quantizer: cell chain, output stage and mode register
// Takes one pixel word per clock and returns one recolored word per clock, in order, while
// the result port keeps ready high. Mode 0 maps each channel through a fixed 8-entry table,
// mode 1 replaces the pixel by the nearest palette color (sum of per-channel xor, ties to
// the lowest index) and reports its index, modes 2 and 3 pass the pixel through. The search
// runs down a chain of one cell per palette color, min(NUM_COLORS, 10) cells, followed by an
// output register. Each stage holds its word when the next is full, so bubbles close up under
// back-pressure. The user must write color_mode only while the block is empty; the block
// itself does not enforce it.
module palette_color_quantizer
  import pcq_pkg::*;
#(
  parameter int unsigned NUM_COLORS = 10
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_data_i,
  pcq_pix_if.sink    pix_in_i,
  pcq_res_if.source  res_out_o
);

  localparam int unsigned NUM_CELLS = (NUM_COLORS < PAL_LEN) ? NUM_COLORS : PAL_LEN;

  logic [1:0] color_mode_q;
  logic       stg_valid [NUM_CELLS+1];
  logic       stg_ready [NUM_CELLS+1];
  cell_word_t stg_word  [NUM_CELLS+1];

  // mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_mode_q <= MODE_TABLE;
    end else if (cfg_we_i) begin
      color_mode_q <= cfg_data_i;
    end
  end

  // chain head
  assign stg_valid[0]       = pix_in_i.valid;
  assign pix_in_i.ready     = stg_ready[0];
  assign stg_word[0].red    = pix_in_i.pixel_red;
  assign stg_word[0].green  = pix_in_i.pixel_green;
  assign stg_word[0].blue   = pix_in_i.pixel_blue;
  assign stg_word[0].mode   = color_mode_q;
  assign stg_word[0].score  = 10'd0;
  assign stg_word[0].idx    = 4'd0;

  // one cell per palette color
  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    pcq_cell #(
      .IDX(k)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .in_valid_i (stg_valid[k]),
      .in_ready_o (stg_ready[k]),
      .in_word_i  (stg_word[k]),
      .out_valid_o(stg_valid[k+1]),
      .out_ready_i(stg_ready[k+1]),
      .out_word_o (stg_word[k+1])
    );
  end

  // output register
  pcq_out_stage u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(stg_valid[NUM_CELLS]),
    .in_ready_o(stg_ready[NUM_CELLS]),
    .in_word_i (stg_word[NUM_CELLS]),
    .res_o     (res_out_o)
  );

`ifndef SYNTHESIS
  // the reported index always names a searched palette color
  a_entry_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_out_o.valid |-> (res_out_o.chosen_entry < NUM_CELLS))
    else $error("chosen entry outside the searched palette");

  // input stalls only when the whole chain is full and the output is blocked
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pix_in_i.ready |-> (stg_valid[NUM_CELLS] && res_out_o.valid && !res_out_o.ready))
    else $error("input stalled with room in the chain");

  // a word in the last cell moves on when the output register drains
  a_last_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stg_valid[NUM_CELLS] && res_out_o.ready) |=> res_out_o.valid)
    else $error("last cell word not taken by the output stage");
`endif

endmodule

### verif/palette_color_quantizer_tb.sv
// self-checking stream testbench for the palette color quantizer
module palette_color_quantizer_tb
  import pcq_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_COLORS   = 10;
  localparam int unsigned SEARCH_LEN   = (NUM_COLORS < PAL_LEN) ? NUM_COLORS : PAL_LEN;
  localparam int unsigned PIPE_DEPTH   = SEARCH_LEN + 1;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned PRINT_LIMIT  = 40;
  localparam logic [1:0]  MODE_RSVD    = 2'd3;
  localparam int unsigned NUM_DIRECTED = 22;
  localparam int unsigned NUM_PHASES   = 7;

  // recolored word as seen on the result port
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [3:0] entry;
  } recolor_t;

  // one directed stimulus row, with a typed-in answer where it is obvious
  typedef struct packed {
    logic [1:0]  mode;
    logic [23:0] rgb;
    logic        typed;
    recolor_t    want;
  } stim_row_t;

  // per-channel quantize levels and palette colors
  localparam logic [7:0] LEVEL_RED   [8] = '{8'h00, 8'h20, 8'h20, 8'h80,
                                              8'h80, 8'he0, 8'he0, 8'he0};
  localparam logic [7:0] LEVEL_GREEN [8] = '{8'h00, 8'h20, 8'h20, 8'h20,
                                              8'h20, 8'h80, 8'h80, 8'he0};
  localparam logic [7:0] LEVEL_BLUE  [8] = '{8'h00, 8'h20, 8'h20, 8'h40,
                                              8'h60, 8'h60, 8'h60, 8'he0};
  localparam logic [23:0] SWATCH [10] = '{24'h000000, 24'h2f002f, 24'h204020, 24'h8080b0,
                                          24'he0b000, 24'hb01020, 24'he08080, 24'he06020,
                                          24'he0b020, 24'h80e0e0};

  // directed rows: extremes, level boundaries, every swatch, a tie, every mode
  localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{MODE_TABLE,   24'h000000, 1'b1, 28'h0000000},
    '{MODE_TABLE,   24'hffffff, 1'b1, 28'he0e0e00},
    '{MODE_TABLE,   24'h1f1f1f, 1'b1, 28'h0000000},
    '{MODE_TABLE,   24'h202020, 1'b1, 28'h2020200},
    '{MODE_TABLE,   24'ha0c0e0, 1'b0, 28'h0000000},
    '{MODE_NEAREST, 24'h000000, 1'b1, 28'h0000000},
    '{MODE_NEAREST, 24'h2f0000, 1'b1, 28'h0000000},
    '{MODE_NEAREST, 24'h2f002f, 1'b1, 28'h2f002f1},
    '{MODE_NEAREST, 24'h204020, 1'b1, 28'h2040202},
    '{MODE_NEAREST, 24'h8080b0, 1'b1, 28'h8080b03},
    '{MODE_NEAREST, 24'he0b000, 1'b1, 28'he0b0004},
    '{MODE_NEAREST, 24'hb01020, 1'b1, 28'hb010205},
    '{MODE_NEAREST, 24'he08080, 1'b1, 28'he080806},
    '{MODE_NEAREST, 24'he06020, 1'b1, 28'he060207},
    '{MODE_NEAREST, 24'he0b020, 1'b1, 28'he0b0208},
    '{MODE_NEAREST, 24'h80e0e0, 1'b1, 28'h80e0e09},
    '{MODE_NEAREST, 24'hffffff, 1'b0, 28'h0000000},
    '{MODE_PASS,    24'h123456, 1'b1, 28'h1234560},
    '{MODE_PASS,    24'hff00a5, 1'b1, 28'hff00a50},
    '{MODE_RSVD,    24'hffffff, 1'b1, 28'hffffff0},
    '{MODE_RSVD,    24'h00ff80, 1'b1, 28'h00ff800},
    '{MODE_TABLE,   24'h6b9fd4, 1'b0, 28'h0000000}
  };

  // random phases: mode and number of pixels
  localparam logic [1:0]  PHASE_MODE  [NUM_PHASES] = '{MODE_NEAREST, MODE_TABLE, MODE_PASS,
                                                        MODE_RSVD, MODE_NEAREST, MODE_TABLE,
                                                        MODE_NEAREST};
  localparam int unsigned PHASE_ITEMS [NUM_PHASES] = '{300, 250, 150, 100, 400, 150, 150};

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_data;

  pcq_pix_if pix ();
  pcq_res_if res ();

  recolor_t    expected_words [$];
  logic [1:0]  cur_mode;
  int unsigned err_count;
  int unsigned cycle_count;
  int unsigned burst_left;
  int unsigned ready_left;
  bit          gap_en;
  bit          stall_en;

  palette_color_quantizer #(
    .NUM_COLORS(NUM_COLORS)
  ) dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_we_i  (cfg_we),
    .cfg_data_i(cfg_data),
    .pix_in_i  (pix),
    .res_out_o (res)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // expected recolored word for one pixel under a given mode
  function automatic recolor_t recolor_pixel(input logic [1:0] mode, input logic [7:0] r,
                                             input logic [7:0] g, input logic [7:0] b);
    recolor_t    w;
    logic [9:0]  best;
    logic [9:0]  score;
    logic [23:0] c;
    w = '{r, g, b, 4'd0};
    case (mode)
      MODE_TABLE: begin
        w.red   = LEVEL_RED[r[7:5]];
        w.green = LEVEL_GREEN[g[7:5]];
        w.blue  = LEVEL_BLUE[b[7:5]];
      end
      MODE_NEAREST: begin
        // xor metric, strict less-than keeps the lowest index on a tie
        best = 10'd1023;
        for (int k = 0; k < SEARCH_LEN; k++) begin
          c     = SWATCH[k];
          score = {2'b00, c[23:16] ^ r} + {2'b00, c[15:8] ^ g} + {2'b00, c[7:0] ^ b};
          if (k == 0 || score < best) begin
            best    = score;
            w.red   = c[23:16];
            w.green = c[15:8];
            w.blue  = c[7:0];
            w.entry = 4'(k);
          end
        end
      end
      default: ;
    endcase
    return w;
  endfunction

  // mismatch reporting
  task automatic flag_error(input string msg);
    err_count++;
    if (err_count <= PRINT_LIMIT) $display("ERROR @%0t: %s", $time, msg);
  endtask

  // result checker
  always @(posedge clk) begin
    recolor_t want;
    if (rst_n && res.valid && res.ready) begin
      if (expected_words.size() == 0) begin
        flag_error($sformatf("unexpected word %h %h %h entry %0d", res.out_red,
                             res.out_green, res.out_blue, res.chosen_entry));
      end else begin
        want = expected_words.pop_front();
        if (res.out_red !== want.red)
          flag_error($sformatf("red got %h want %h", res.out_red, want.red));
        if (res.out_green !== want.green)
          flag_error($sformatf("green got %h want %h", res.out_green, want.green));
        if (res.out_blue !== want.blue)
          flag_error($sformatf("blue got %h want %h", res.out_blue, want.blue));
        if (res.chosen_entry !== want.entry)
          flag_error($sformatf("entry got %0d want %0d", res.chosen_entry, want.entry));
      end
    end
  end

  // receiver: runs of ready high and low when stalling is on
  initial begin
    res.ready <= 1'b0;
    ready_left = 0;
    forever begin
      @(posedge clk);
      if (!stall_en) begin
        res.ready <= 1'b1;
      end else if (ready_left == 0) begin
        res.ready <= ~res.ready;
        ready_left = res.ready ? $urandom_range(1, 6) : $urandom_range(1, 16);
      end else begin
        ready_left--;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // send one pixel word, with bursts and gaps when idling is on
  task automatic push_pixel(input logic [23:0] rgb, input bit typed, input recolor_t want);
    if (gap_en && burst_left == 0) begin
      pix.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    pix.valid       <= 1'b1;
    pix.pixel_red   <= rgb[23:16];
    pix.pixel_green <= rgb[15:8];
    pix.pixel_blue  <= rgb[7:0];
    do @(posedge clk); while (!pix.ready);
    expected_words.push_back(typed ? want
                                   : recolor_pixel(cur_mode, rgb[23:16], rgb[15:8], rgb[7:0]));
    if (burst_left != 0) burst_left--;
  endtask

  // stop sending and wait for every outstanding word
  task automatic drain_stream();
    pix.valid <= 1'b0;
    burst_left = 0;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  // mode register write, only with the block empty
  task automatic write_mode(input logic [1:0] mode);
    drain_stream();
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= mode;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_mode = mode;
  endtask

  // stimulus
  initial begin
    logic [23:0] rgb;
    logic [23:0] base;
    logic [7:0]  chan [3];
    err_count   = 0;
    cycle_count = 0;
    burst_left  = 0;
    gap_en      = 1'b1;
    stall_en    = 1'b1;
    cur_mode    = MODE_TABLE;
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_data        <= MODE_TABLE;
    pix.valid       <= 1'b0;
    pix.pixel_red   <= 8'h00;
    pix.pixel_green <= 8'h00;
    pix.pixel_blue  <= 8'h00;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, starting from the reset mode
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      if (DIRECTED_ROWS[i].mode != cur_mode) write_mode(DIRECTED_ROWS[i].mode);
      push_pixel(DIRECTED_ROWS[i].rgb, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
    end

    // random phases, first one with no idling on either side
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_mode(PHASE_MODE[p]);
      gap_en   = (p != 0) && ($urandom_range(0, 3) != 0);
      stall_en = (p != 0) && ($urandom_range(0, 3) != 0);
      for (int n = 0; n < PHASE_ITEMS[p]; n++) begin
        // hold off mid-phase until the pipeline is empty
        if (p == 4 && n == PHASE_ITEMS[p] / 2) begin
          drain_stream();
          @(posedge clk);
        end
        case (cur_mode)
          MODE_NEAREST: begin
            case ($urandom_range(0, 3))
              0, 1: begin
                // swatch with a few bits flipped
                base = SWATCH[$urandom_range(0, PAL_LEN - 1)];
                rgb  = base ^ (24'($urandom) & 24'($urandom) & 24'($urandom));
              end
              2: rgb = 24'($urandom);
              default: begin
                for (int c = 0; c < 3; c++) begin
                  case ($urandom_range(0, 2))
                    0:       chan[c] = 8'h00;
                    1:       chan[c] = 8'hff;
                    default: chan[c] = 8'($urandom);
                  endcase
                end
                rgb = {chan[0], chan[1], chan[2]};
              end
            endcase
          end
          MODE_TABLE: begin
            // level edges are as likely as the middle of a level
            for (int c = 0; c < 3; c++) begin
              case ($urandom_range(0, 2))
                0:       chan[c] = {3'($urandom), 5'h00};
                1:       chan[c] = {3'($urandom), 5'h1f};
                default: chan[c] = 8'($urandom);
              endcase
            end
            rgb = {chan[0], chan[1], chan[2]};
          end
          default: rgb = 24'($urandom);
        endcase
        push_pixel(rgb, 1'b0, '0);
      end
    end

    // wait out the pipeline, then a quiet stretch for stray words
    drain_stream();
    repeat (3 * PIPE_DEPTH) @(posedge clk);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
